### sv/nlb_pkg.sv
// shared types, sizes and helpers for the neighborhood load balance policy
package nlb_pkg;

    localparam int LOAD_W  = 16;
    localparam int MAX_NB  = 8;
    localparam int NB_IW   = (MAX_NB > 1) ? $clog2(MAX_NB) : 1;
    localparam int NB_CW   = $clog2(MAX_NB + 1);
    localparam int SUM_W   = LOAD_W + NB_CW;
    localparam int DIV_W   = $clog2(MAX_NB + 2);
    localparam int DCNT_W  = $clog2(SUM_W);
    localparam int SLOT_W  = 3;
    localparam int NBC_W   = 4;
    localparam int CFG_W   = 16;
    localparam int CFG_AW  = 2;

    // stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_RUN    = 3'd1,
        OP_STATUS = 3'd2,
        OP_BATCH  = 3'd3,
        OP_TICK   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        KIND_RUN    = 2'd0,
        KIND_EXPORT = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [CFG_AW-1:0] {
        CFG_NB_COUNT     = 2'd0,
        CFG_STATUS_DELTA = 2'd1,
        CFG_BATCH_MAX    = 2'd2
    } t_cfg_idx;

    function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] a,
                                                  input logic [LOAD_W-1:0] b);
        logic [LOAD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LOAD_W] ? LOAD_MAX : s[LOAD_W-1:0];
    endfunction

endpackage

### sv/neighborhood_load_balance_policy.sv
// neighborhood averaging load balance policy: event sequencer over two load tables
//
//  channel      | dir | handshake                      | contents
//  -------------+-----+--------------------------------+-------------------------------------
//  s_axis       | in  | tvalid/tready                  | one event request (tuser = operation)
//  m_axis       | out | tvalid/tready, tlast           | result requests (tuser = kind)
//  cfg          | in  | i_cfg_we, i_cfg_addr           | neighbor_count, status_delta, batch_max
//
// steps: add, status, batch and undefined events are handled in idle. a run with nonzero
// own load, or a tick, runs a balance check: a read and an accumulate per active slot to
// sum the neighbor table, the bit-serial divider for the average, then a read and an
// evaluate per visited slot in the read-modify-write pass over the tables, plus a flush.
// the tables sit in single-port-write synchronous memories; each visited slot costs one
// read and, when it yields a result, one write-back.
// reset: i_rst_n is synchronous, active low; it clears own load, the table valid bits
// (an unwritten entry reads as zero) and restores the register defaults.
// stalls: a full output register holds the pass in place; the next event is taken
// only once every result of the current one has left the pending stage.
module neighborhood_load_balance_policy (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // cfg write port
    input  logic                             i_cfg_we,
    input  logic [nlb_pkg::CFG_AW-1:0]       i_cfg_addr,
    input  logic [nlb_pkg::CFG_W-1:0]        i_cfg_data,
    // event requests
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [2:0] neighbor_slot, [3] from_neighbor, [19:4] neighbor_load,
    // [35:20] batch_count, [39:36] zero
    input  logic [nlb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]                       s_axis_tuser,
    // result requests
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] neighbor_slot_res, [18:3] amount, [34:19] own_load, [39:35] zero
    output logic [nlb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] kind
    output logic [1:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);
    import nlb_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_SUM_RD  = 8'b0000_0010,
        S_SUM_ACC = 8'b0000_0100,
        S_DIV     = 8'b0000_1000,
        S_CHK     = 8'b0001_0000,
        S_RD      = 8'b0010_0000,
        S_EVAL    = 8'b0100_0000,
        S_FLUSH   = 8'b1000_0000
    } t_state;

    // request fields
    logic [SLOT_W-1:0] in_slot;
    logic              in_known;
    logic [LOAD_W-1:0] in_load;
    logic [LOAD_W-1:0] in_count;
    t_op               in_op;

    assign in_slot  = s_axis_tdata[2:0];
    assign in_known = s_axis_tdata[3];
    assign in_load  = s_axis_tdata[19:4];
    assign in_count = s_axis_tdata[35:20];
    assign in_op    = t_op'(s_axis_tuser);

    // configuration
    logic [NBC_W-1:0]  r_nb_count;
    logic [LOAD_W-1:0] r_status_delta;
    logic [LOAD_W-1:0] r_batch_max;

    // control and working registers
    t_state            r_state, n_state;
    logic [LOAD_W-1:0] r_own, n_own;
    logic [NB_CW-1:0]  r_idx, n_idx;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [DIV_W:0]    r_rem, n_rem;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic              r_export, n_export;

    // pending result: held back until we know whether another one follows
    logic              r_pend_valid, n_pend_valid;
    t_kind             r_pend_kind, n_pend_kind;
    logic [SLOT_W-1:0] r_pend_slot, n_pend_slot;
    logic [LOAD_W-1:0] r_pend_amount, n_pend_amount;
    logic [LOAD_W-1:0] r_pend_own, n_pend_own;

    // output register
    logic              r_out_valid, n_out_valid;
    t_kind             r_out_kind, n_out_kind;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic [LOAD_W-1:0] r_out_amount, n_out_amount;
    logic [LOAD_W-1:0] r_out_own, n_out_own;
    logic              r_out_last, n_out_last;

    // table memories: neighbor load and last reported load
    logic [LOAD_W-1:0] nl_mem [MAX_NB];
    logic [LOAD_W-1:0] lr_mem [MAX_NB];
    logic [MAX_NB-1:0] r_nl_vld, r_lr_vld;
    logic [LOAD_W-1:0] r_nl_q, r_lr_q;
    logic              r_nl_ok, r_lr_ok;
    logic [LOAD_W-1:0] nl_rd, lr_rd;

    logic              rd_en;
    logic [NB_IW-1:0]  rd_addr;
    logic              nl_we, lr_we;
    logic [NB_IW-1:0]  nl_wa, lr_wa;
    logic [LOAD_W-1:0] nl_wd, lr_wd;

    // derived values
    logic [NB_CW-1:0]  active;
    logic              slot_ok;
    logic [DIV_W-1:0]  divisor;
    logic [DIV_W:0]    rem_sh;
    logic              div_ge;
    logic [LOAD_W-1:0] avg;
    logic              out_free;
    logic              above;

    // balance pass evaluation
    logic [LOAD_W-1:0] deficit, surplus, want, diff;
    logic              go;
    t_kind             new_kind;
    logic [LOAD_W-1:0] new_amount, new_own;

    assign active   = (32'(r_nb_count) > MAX_NB) ? NB_CW'(MAX_NB) : NB_CW'(r_nb_count);
    assign slot_ok  = in_known && (32'(in_slot) < 32'(active));
    assign divisor  = DIV_W'(active) + DIV_W'(1);
    assign rem_sh   = {r_rem[DIV_W-1:0], r_quo[SUM_W-1]};
    assign div_ge   = rem_sh >= {1'b0, divisor};
    assign avg      = r_quo[LOAD_W-1:0];
    assign out_free = !r_out_valid || m_axis_tready;
    assign above    = r_own > avg;
    assign nl_rd    = r_nl_ok ? r_nl_q : '0;
    assign lr_rd    = r_lr_ok ? r_lr_q : '0;
    assign rd_addr  = r_idx[NB_IW-1:0];

    // per-slot decision of the balance pass
    always_comb begin
        deficit    = avg - nl_rd;
        surplus    = r_own - avg;
        want       = (deficit < surplus) ? deficit : surplus;
        want       = (want < r_batch_max) ? want : r_batch_max;
        diff       = (r_own >= lr_rd) ? (r_own - lr_rd) : (lr_rd - r_own);
        new_kind   = r_export ? KIND_EXPORT : KIND_STATUS;
        new_amount = r_export ? want : '0;
        new_own    = r_export ? (r_own - want) : r_own;
        if (r_export) begin
            go = (nl_rd < avg) && (want != '0);
        end else begin
            go = diff >= r_status_delta;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_own         = r_own;
        n_idx         = r_idx;
        n_quo         = r_quo;
        n_rem         = r_rem;
        n_dcnt        = r_dcnt;
        n_export      = r_export;
        n_pend_valid  = r_pend_valid;
        n_pend_kind   = r_pend_kind;
        n_pend_slot   = r_pend_slot;
        n_pend_amount = r_pend_amount;
        n_pend_own    = r_pend_own;
        n_out_valid   = r_out_valid;
        n_out_kind    = r_out_kind;
        n_out_slot    = r_out_slot;
        n_out_amount  = r_out_amount;
        n_out_own     = r_out_own;
        n_out_last    = r_out_last;
        rd_en         = 1'b0;
        nl_we         = 1'b0;
        nl_wa         = rd_addr;
        nl_wd         = '0;
        lr_we         = 1'b0;
        lr_wa         = rd_addr;
        lr_wd         = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (in_op)
                        OP_ADD: begin
                            n_own = sat_add(r_own, LOAD_W'(1));
                        end
                        OP_RUN: begin
                            if (r_own != '0) begin
                                n_own         = r_own - LOAD_W'(1);
                                n_pend_valid  = 1'b1;
                                n_pend_kind   = KIND_RUN;
                                n_pend_slot   = '0;
                                n_pend_amount = '0;
                                n_pend_own    = r_own - LOAD_W'(1);
                                n_idx         = '0;
                                n_quo         = SUM_W'(r_own - LOAD_W'(1));
                                n_state       = (active == '0) ? S_FLUSH : S_SUM_RD;
                            end
                        end
                        OP_STATUS: begin
                            nl_we = slot_ok;
                            nl_wa = NB_IW'(in_slot);
                            nl_wd = in_load;
                        end
                        OP_BATCH: begin
                            nl_we = slot_ok;
                            nl_wa = NB_IW'(in_slot);
                            nl_wd = in_load;
                            n_own = sat_add(r_own, in_count);
                        end
                        OP_TICK: begin
                            n_idx   = '0;
                            n_quo   = SUM_W'(r_own);
                            n_state = (active == '0) ? S_FLUSH : S_SUM_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SUM_RD: begin
                rd_en   = 1'b1;
                n_state = S_SUM_ACC;
            end
            S_SUM_ACC: begin
                n_quo = r_quo + SUM_W'(nl_rd);
                n_idx = r_idx + NB_CW'(1);
                if (r_idx + NB_CW'(1) == active) begin
                    n_rem   = '0;
                    n_dcnt  = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_SUM_RD;
                end
            end
            S_DIV: begin
                n_rem  = div_ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
                n_quo  = {r_quo[SUM_W-2:0], div_ge};
                n_dcnt = r_dcnt + DCNT_W'(1);
                if (r_dcnt == DCNT_W'(SUM_W - 1)) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_export = above;
                n_idx    = '0;
                n_state  = S_RD;
            end
            S_RD: begin
                if (r_idx == active || (r_export && !above)) begin
                    n_state = S_FLUSH;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!go) begin
                    n_idx   = r_idx + NB_CW'(1);
                    n_state = S_RD;
                end else if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = r_pend_kind;
                        n_out_slot   = r_pend_slot;
                        n_out_amount = r_pend_amount;
                        n_out_own    = r_pend_own;
                        n_out_last   = 1'b0;
                    end
                    n_pend_valid  = 1'b1;
                    n_pend_kind   = new_kind;
                    n_pend_slot   = SLOT_W'(r_idx);
                    n_pend_amount = new_amount;
                    n_pend_own    = new_own;
                    // write back: export raises the neighbor, both record what we told it
                    nl_we = r_export;
                    nl_wd = sat_add(nl_rd, want);
                    lr_we = 1'b1;
                    lr_wd = new_own;
                    n_own   = new_own;
                    n_idx   = r_idx + NB_CW'(1);
                    n_state = S_RD;
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_pend_kind;
                    n_out_slot   = r_pend_slot;
                    n_out_amount = r_pend_amount;
                    n_out_own    = r_pend_own;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_own          <= '0;
            r_idx          <= '0;
            r_pend_valid   <= 1'b0;
            r_out_valid    <= 1'b0;
            r_nl_vld       <= '0;
            r_lr_vld       <= '0;
            r_nb_count     <= NBC_W'(6);
            r_status_delta <= LOAD_W'(2);
            r_batch_max    <= LOAD_W'(64);
        end else begin
            r_state      <= n_state;
            r_own        <= n_own;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (nl_we) begin
                r_nl_vld[nl_wa] <= 1'b1;
            end
            if (lr_we) begin
                r_lr_vld[lr_wa] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_NB_COUNT:     r_nb_count     <= i_cfg_data[NBC_W-1:0];
                    CFG_STATUS_DELTA: r_status_delta <= i_cfg_data[LOAD_W-1:0];
                    CFG_BATCH_MAX:    r_batch_max    <= i_cfg_data[LOAD_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_quo         <= n_quo;
        r_rem         <= n_rem;
        r_dcnt        <= n_dcnt;
        r_export      <= n_export;
        r_pend_kind   <= n_pend_kind;
        r_pend_slot   <= n_pend_slot;
        r_pend_amount <= n_pend_amount;
        r_pend_own    <= n_pend_own;
        r_out_kind    <= n_out_kind;
        r_out_slot    <= n_out_slot;
        r_out_amount  <= n_out_amount;
        r_out_own     <= n_out_own;
        r_out_last    <= n_out_last;
    end

    // table memories, one write and one registered read each per cycle
    always_ff @(posedge i_clk) begin
        if (nl_we) begin
            nl_mem[nl_wa] <= nl_wd;
        end
        if (lr_we) begin
            lr_mem[lr_wa] <= lr_wd;
        end
    end

    // the pass never reads a slot in the cycle it is written back, so no bypass
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_nl_q  <= nl_mem[rd_addr];
            r_lr_q  <= lr_mem[rd_addr];
            r_nl_ok <= r_nl_vld[rd_addr];
            r_lr_ok <= r_lr_vld[rd_addr];
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{(OUT_TDATA_W - SLOT_W - 2 * LOAD_W){1'b0}},
                            r_out_own, r_out_amount, r_out_slot};

    // nothing left over from the previous event when a new one is taken
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending result left behind at idle");

    // a result not marked last must have a follower waiting
    a_not_last_has_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> r_pend_valid)
        else $error("non-final result without a follower");

    // export slots are only evaluated while still above the average
    a_export_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_export) |-> above)
        else $error("export evaluated at or below average");

    // own load never grows during a balance pass
    a_own_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_state) != S_IDLE) |-> (r_own <= $past(r_own)))
        else $error("own load grew during balance");

endmodule
